FILE: hdl/coh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// coh_pkg
// Shared widths, bin count and per-sector vote coefficients for the cell
// orientation histogram.
// ----------------------------------------------------------------------------
package coh_pkg;

    localparam int GRAD_W  = 8;    // signed gradient width
    localparam int MAG_W   = 8;    // magnitude 0..128
    localparam int BIN_W   = 26;   // accumulator width, wraps
    localparam int NUM_BINS = 9;
    localparam int BIN_IDX_W = 4;  // holds 0..8
    localparam int SEC_W   = 3;    // base sector 0..4
    localparam int COEF_W  = 13;   // signed coefficient, |k| <= 2994
    localparam int CMP_W   = 16;   // threshold compare width

    // Sector thresholds on 64*|dy| against multiples of |dx|
    localparam logic [CMP_W-1:0] THR_0 = 16'd11;
    localparam logic [CMP_W-1:0] THR_1 = 16'd37;
    localparam logic [CMP_W-1:0] THR_2 = 16'd76;
    localparam logic [CMP_W-1:0] THR_3 = 16'd176;

    localparam logic [BIN_IDX_W-1:0] BIN_VERT  = 4'd4;
    localparam logic [BIN_IDX_W-1:0] BIN_HORIZ = 4'd8;
    localparam logic [BIN_IDX_W-1:0] BIN_LAST  = 4'd8;

    localparam logic signed [COEF_W-1:0] K_VERT  = 13'sd1024;
    localparam logic signed [COEF_W-1:0] K_HORIZ = 13'sd1040;

    // v1 = k1x*ax + k1y*ay, v2 = k2x*ax + k2y*ay
    typedef struct packed {
        logic signed [COEF_W-1:0] k1x;
        logic signed [COEF_W-1:0] k1y;
        logic signed [COEF_W-1:0] k2x;
        logic signed [COEF_W-1:0] k2y;
    } t_coef;

    function automatic t_coef sector_coef(input logic [SEC_W-1:0] sec);
        t_coef c;
        unique case (sec)
            3'd0:    c = '{ 13'sd520,  -13'sd2948,  13'sd520,  13'sd2948};
            3'd1:    c = '{ 13'sd1497, -13'sd2593, -13'sd520,  13'sd2948};
            3'd2:    c = '{ 13'sd2294, -13'sd1924, -13'sd1497, 13'sd2593};
            3'd3:    c = '{ 13'sd2813, -13'sd1024, -13'sd2294, 13'sd1924};
            default: c = '{ 13'sd2994,  13'sd0,    -13'sd2813, 13'sd1024};
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/hog_cell_orientation_histogram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hog_cell_orientation_histogram
// Nine-bin orientation histogram of one cell, built from per-pixel gradients.
// ----------------------------------------------------------------------------
// Path: a cell-end item goes into the input register, then is accumulated
//   into the result register, which drives o_valid.
// Throughput: 1 item per cycle; the input stalls only while a cell-end item
//   sits in the input register and the result register is full and stalled.
// Reset (i_rst_n low, synchronous): both valid flags drop and all nine
//   accumulators clear; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hog_cell_orientation_histogram #(
    parameter int BIN_W = coh_pkg::BIN_W
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // pixel item in
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire signed [coh_pkg::GRAD_W-1:0]     i_grad_x,
    input  wire signed [coh_pkg::GRAD_W-1:0]     i_grad_y,
    input  wire                                  i_cell_end,
    // histogram item out
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic signed [BIN_W-1:0]              o_bin_0,
    output logic signed [BIN_W-1:0]              o_bin_1,
    output logic signed [BIN_W-1:0]              o_bin_2,
    output logic signed [BIN_W-1:0]              o_bin_3,
    output logic signed [BIN_W-1:0]              o_bin_4,
    output logic signed [BIN_W-1:0]              o_bin_5,
    output logic signed [BIN_W-1:0]              o_bin_6,
    output logic signed [BIN_W-1:0]              o_bin_7,
    output logic signed [BIN_W-1:0]              o_bin_8
);

    localparam int NB  = coh_pkg::NUM_BINS;
    localparam int IW  = coh_pkg::BIN_IDX_W;
    localparam int MW  = coh_pkg::MAG_W;
    localparam int CW  = coh_pkg::COEF_W;
    localparam int TW  = coh_pkg::CMP_W;

    // ---------------- input register ----------------
    logic                              r_s1_valid;
    logic signed [coh_pkg::GRAD_W-1:0] r_gx, r_gy;
    logic                              r_end;

    // ---------------- accumulators and result register ----------------
    logic signed [BIN_W-1:0] r_sum [NB];
    logic signed [BIN_W-1:0] n_sum [NB];
    logic signed [BIN_W-1:0] r_out [NB];
    logic                    r_out_valid;

    // Output register can take a new histogram this edge
    logic out_free;
    // Item in the input register leaves this edge
    logic s1_go;
    logic in_acc;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_go    = r_s1_valid && (!r_end || out_free);
    assign o_stall  = r_s1_valid && !s1_go;
    assign in_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_gx  <= i_grad_x;
            r_gy  <= i_grad_y;
            r_end <= i_cell_end;
        end
    end

    // ---------------- vote computation ----------------
    // Magnitudes; -128 comes out as 128, which still fits in 8 unsigned bits.
    logic          nx, ny;
    logic [MW-1:0] ax, ay;
    assign nx = r_gx[coh_pkg::GRAD_W-1];
    assign ny = r_gy[coh_pkg::GRAD_W-1];
    assign ax = nx ? MW'(-r_gx) : MW'(r_gx);
    assign ay = ny ? MW'(-r_gy) : MW'(r_gy);

    // Sector search: 64*ay against fixed multiples of ax
    logic [TW-1:0]              ys, ax_w;
    logic [coh_pkg::SEC_W-1:0]  sec;
    assign ys   = TW'({ay, 6'b0});
    assign ax_w = TW'(ax);

    always_comb begin
        if (ys < coh_pkg::THR_0 * ax_w) begin
            sec = 3'd0;
        end else if (ys < coh_pkg::THR_1 * ax_w) begin
            sec = 3'd1;
        end else if (ys < coh_pkg::THR_2 * ax_w) begin
            sec = 3'd2;
        end else if (ys < coh_pkg::THR_3 * ax_w) begin
            sec = 3'd3;
        end else begin
            sec = 3'd4;
        end
    end

    // Pick coefficients and bin; special axes bypass the sector table.
    coh_pkg::t_coef coef, sec_c;
    logic [IW-1:0]  bin_a, bin_b, base_bin;
    logic           vote, mirror;

    assign sec_c = coh_pkg::sector_coef(sec);

    always_comb begin
        coef     = sec_c;
        base_bin = IW'(sec);
        vote     = 1'b1;
        mirror   = 1'b0;
        if (ax != '0 && ay != '0) begin
            mirror = (nx == ny);
        end else if (ay != '0) begin
            // vertical only: all into bin 4
            coef     = '{'0, coh_pkg::K_VERT, '0, '0};
            base_bin = coh_pkg::BIN_VERT;
        end else if (ax != '0) begin
            // horizontal only: equal split over bins 8 and 0
            coef     = '{coh_pkg::K_HORIZ, '0, coh_pkg::K_HORIZ, '0};
            base_bin = coh_pkg::BIN_HORIZ;
        end else begin
            vote = 1'b0;
        end
    end

    // Four constant-coefficient products, sign-extended into accumulator width
    logic signed [BIN_W-1:0] sx, sy, p1x, p1y, p2x, p2y, v1, v2, va, vb;
    assign sx  = $signed({{(BIN_W-MW){1'b0}}, ax});
    assign sy  = $signed({{(BIN_W-MW){1'b0}}, ay});
    assign p1x = $signed({{(BIN_W-CW){coef.k1x[CW-1]}}, coef.k1x}) * sx;
    assign p1y = $signed({{(BIN_W-CW){coef.k1y[CW-1]}}, coef.k1y}) * sy;
    assign p2x = $signed({{(BIN_W-CW){coef.k2x[CW-1]}}, coef.k2x}) * sx;
    assign p2y = $signed({{(BIN_W-CW){coef.k2y[CW-1]}}, coef.k2y}) * sy;
    assign v1  = p1x + p1y;
    assign v2  = p2x + p2y;

    // Mirror into the upper half when the gradient signs agree
    assign bin_a = mirror ? IW'(coh_pkg::BIN_LAST - base_bin) : base_bin;
    assign bin_b = (bin_a == coh_pkg::BIN_LAST) ? '0 : IW'(bin_a + 1'b1);
    assign va    = mirror ? v2 : v1;
    assign vb    = mirror ? v1 : v2;

    // ---------------- accumulate ----------------
    always_comb begin
        for (int b = 0; b < NB; b++) begin
            n_sum[b] = r_sum[b];
            if (vote && bin_a == IW'(b)) begin
                n_sum[b] = n_sum[b] + va;
            end
            if (vote && bin_b == IW'(b)) begin
                n_sum[b] = n_sum[b] + vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NB; b++) begin
                r_sum[b] <= '0;
            end
        end else if (s1_go) begin
            for (int b = 0; b < NB; b++) begin
                r_sum[b] <= r_end ? '0 : n_sum[b];
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_end) begin
            for (int b = 0; b < NB; b++) begin
                r_out[b] <= n_sum[b];
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_bin_0 = r_out[0];
    assign o_bin_1 = r_out[1];
    assign o_bin_2 = r_out[2];
    assign o_bin_3 = r_out[3];
    assign o_bin_4 = r_out[4];
    assign o_bin_5 = r_out[5];
    assign o_bin_6 = r_out[6];
    assign o_bin_7 = r_out[7];
    assign o_bin_8 = r_out[8];

`ifndef NO_ASSERTIONS
    // Only a waiting cell-end item may hold the input back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_end && r_out_valid && i_stall))
        else $error("input stalled without a blocked cell-end item");

    // A cell-end item leaving the input register produces a result
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_end) |=> r_out_valid)
        else $error("cell end did not load the result register");

    // Accumulators are cleared after a cell end
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_end) |=> (r_sum[0] == '0 && r_sum[4] == '0 && r_sum[8] == '0))
        else $error("accumulators not cleared after cell end");

    // Sums only move when an item is consumed
    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_go |=> ($stable(r_sum[0]) && $stable(r_sum[5])))
        else $error("accumulator changed without an item");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nine-bin cell orientation histogram. Pixel
// items go in through a directed table and then random cells; a local
// histogram predictor or a typed table row forms each expected cell result;
// each item out is compared bin by bin against the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = coh_pkg::NUM_BINS;
    localparam int BW = coh_pkg::BIN_W;

    localparam int RANDOM_PIXELS = 1550;
    localparam int OVERFLOW_LEN  = 280;   // enough near-max votes to wrap 26 bits
    localparam int LONG_HOLD     = 300;   // receiver hold-off, in cycles
    localparam int DRAIN_LIMIT   = 5000;
    localparam int N_DIRECTED    = 22;

    // Orientation sector limits on 64*|dy| against k*|dx|
    localparam int SECTOR_LIMIT [4] = '{11, 37, 76, 176};
    // Per-sector vote weights: {v1 by ax, v1 by ay, v2 by ax, v2 by ay}
    localparam int VOTE_K [5][4] = '{
        '{ 520, -2948,   520, 2948},
        '{1497, -2593,  -520, 2948},
        '{2294, -1924, -1497, 2593},
        '{2813, -1024, -2294, 1924},
        '{2994,     0, -2813, 1024}
    };
    localparam int VERT_BIN    = 4;
    localparam int HORIZ_BIN   = 8;
    localparam int VERT_SCALE  = 1024;
    localparam int HORIZ_SCALE = 1040;

    typedef logic signed [coh_pkg::GRAD_W-1:0] t_grad;
    typedef logic [NB-1:0][BW-1:0] t_hist;

    // One directed pixel; where typed is set, the cell result is given as
    // at most two nonzero bins straight from the table.
    typedef struct {
        int   gx;
        int   gy;
        logic last;
        bit   typed;
        int   bin_a;
        int   vote_a;
        int   bin_b;
        int   vote_b;
    } t_pixel_row;

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic  i_clk      = 1'b0;
    logic  i_rst_n    = 1'b0;
    logic  i_valid    = 1'b0;
    logic  o_stall;
    t_grad i_grad_x   = '0;
    t_grad i_grad_y   = '0;
    logic  i_cell_end = 1'b0;
    logic  o_valid;
    logic  i_stall    = 1'b0;
    logic signed [BW-1:0] o_bin_0, o_bin_1, o_bin_2, o_bin_3, o_bin_4;
    logic signed [BW-1:0] o_bin_5, o_bin_6, o_bin_7, o_bin_8;
    t_hist dut_bins;

    assign dut_bins = {o_bin_8, o_bin_7, o_bin_6, o_bin_5, o_bin_4,
                       o_bin_3, o_bin_2, o_bin_1, o_bin_0};

    hog_cell_orientation_histogram u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_grad_x   (i_grad_x),
        .i_grad_y   (i_grad_y),
        .i_cell_end (i_cell_end),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_bin_0    (o_bin_0),
        .o_bin_1    (o_bin_1),
        .o_bin_2    (o_bin_2),
        .o_bin_3    (o_bin_3),
        .o_bin_4    (o_bin_4),
        .o_bin_5    (o_bin_5),
        .o_bin_6    (o_bin_6),
        .o_bin_7    (o_bin_7),
        .o_bin_8    (o_bin_8)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_hist cell_sums = '0;          // predicted running sums of the open cell
    t_hist expected_hists [$];      // finished cells not yet seen at the output
    int    n_fail       = 0;
    int    tx_idle_pct  = 35;
    int    rx_idle_pct  = 81;
    bit    hold_request = 1'b0;     // asks the receiver for one long hold-off
    t_pixel_row directed [N_DIRECTED];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Safety net: far beyond a normal run
    initial begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Histogram predictor: adds one pixel's two votes to the open cell.
    // Returns 1 on a cell end, with the finished sums in done_cell.
    // ------------------------------------------------------------------
    function automatic bit accumulate_pixel(input t_grad gx, input t_grad gy,
                                            input logic last, output t_hist done_cell);
        int ax, ay, sec, v1, v2, t;
        bit vote;
        ax   = gx[7] ? -int'(gx) : int'(gx);   // -128 gives 128
        ay   = gy[7] ? -int'(gy) : int'(gy);
        vote = 1'b1;
        sec  = 0;
        v1   = 0;
        v2   = 0;
        if (ax != 0 && ay != 0) begin
            // limits rise, so the lowest limit that holds picks the sector
            sec = 4;
            for (int i = 3; i >= 0; i--) begin
                if (ay * 64 < SECTOR_LIMIT[i] * ax) sec = i;
            end
            v1 = VOTE_K[sec][0] * ax + VOTE_K[sec][1] * ay;
            v2 = VOTE_K[sec][2] * ax + VOTE_K[sec][3] * ay;
            // same-sign gradients mirror the sector and swap the votes
            if (gx[7] == gy[7]) begin
                t   = v1;
                v1  = v2;
                v2  = t;
                sec = 8 - sec;
            end
        end else if (ay != 0) begin
            sec = VERT_BIN;
            v1  = VERT_SCALE * ay;
            v2  = 0;
        end else if (ax != 0) begin
            sec = HORIZ_BIN;
            v1  = HORIZ_SCALE * ax;
            v2  = v1;
        end else begin
            vote = 1'b0;
        end
        if (vote) begin
            // 26-bit sums wrap, no saturation
            cell_sums[sec]          = cell_sums[sec] + v1[BW-1:0];
            cell_sums[(sec + 1) % NB] = cell_sums[(sec + 1) % NB] + v2[BW-1:0];
        end
        done_cell = cell_sums;
        if (last) cell_sums = '0;
        return last;
    endfunction

    function automatic t_grad random_grad();
        int m;
        m = $urandom_range(1, 15);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return t_grad'(-128);
            2:       return $urandom_range(0, 1) ? t_grad'(127) : t_grad'(-127);
            3, 4, 5: return t_grad'($urandom_range(0, 1) ? m : -m);
            default: return t_grad'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: random idle cycles, then hold the item until accepted.
    // ------------------------------------------------------------------
    task automatic send_pixel(input t_grad gx, input t_grad gy, input logic last,
                              input bit typed, input t_hist want);
        t_hist h;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_grad_x   <= gx;
        i_grad_y   <= gy;
        i_cell_end <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (accumulate_pixel(gx, gy, last, h)) expected_hists.push_back(typed ? want : h);
    endtask

    // Sender pause until every finished cell has come out
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_hists.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: check accepted histogram items, drive random stall and
    // one long hold-off counted here.
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin : rx_side
        t_hist want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_hists.size() == 0) begin
                    $error("histogram item out with none expected");
                    n_fail++;
                end else begin
                    want = expected_hists.pop_front();
                    for (int k = 0; k < NB; k++) begin
                        if (dut_bins[k] !== want[k]) begin
                            $error("bin_%0d: expected %0d, actual %0d", k,
                                   $signed(want[k]), $signed(dut_bins[k]));
                            n_fail++;
                        end
                    end
                end
            end
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_hist want;
        int    items, phase, new_phase, n_ovf, len, m, waited;
        int    ovf_at [2];

        // gx, gy, last, typed, bin/vote pairs of the typed result
        directed = '{
            // lone pixels after reset: result readable at a glance
            '{ 127,    0, 1'b1, 1'b1, 0, 132080, 8, 132080},   // horizontal only
            '{   0, -127, 1'b1, 1'b1, 4, 130048, 5,      0},   // vertical only
            '{   0,    0, 1'b1, 1'b1, 0,      0, 0,      0},   // zero gradient
            '{-128,    0, 1'b1, 1'b1, 0, 133120, 8, 133120},   // most negative x
            '{   0, -128, 1'b1, 1'b1, 4, 131072, 5,      0},   // most negative y
            // every sector with opposite and with matching signs
            '{ 100,  -10, 1'b0, 1'b0, 0, 0, 0, 0},
            '{ 100,   10, 1'b1, 1'b0, 0, 0, 0, 0},
            '{-100,   30, 1'b0, 1'b0, 0, 0, 0, 0},
            '{-100,  -30, 1'b1, 1'b0, 0, 0, 0, 0},
            '{ 100,  -80, 1'b0, 1'b0, 0, 0, 0, 0},
            '{ 100,   80, 1'b1, 1'b0, 0, 0, 0, 0},
            '{ -50,  100, 1'b0, 1'b0, 0, 0, 0, 0},
            '{ -50, -100, 1'b1, 1'b0, 0, 0, 0, 0},
            '{  10, -100, 1'b0, 1'b0, 0, 0, 0, 0},
            '{  10,  100, 1'b1, 1'b0, 0, 0, 0, 0},
            // exactly on each sector limit
            '{  64,   11, 1'b0, 1'b0, 0, 0, 0, 0},
            '{ -64,  -37, 1'b0, 1'b0, 0, 0, 0, 0},
            '{  64,  -76, 1'b1, 1'b0, 0, 0, 0, 0},
            '{  32,   88, 1'b0, 1'b0, 0, 0, 0, 0},
            // extremes on both axes
            '{ 127, -127, 1'b0, 1'b0, 0, 0, 0, 0},
            '{-128,  127, 1'b0, 1'b0, 0, 0, 0, 0},
            '{-128, -128, 1'b1, 1'b0, 0, 0, 0, 0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[r]) begin
            want = '0;
            if (directed[r].typed) begin
                want[directed[r].bin_a] = want[directed[r].bin_a] + BW'(directed[r].vote_a);
                want[directed[r].bin_b] = want[directed[r].bin_b] + BW'(directed[r].vote_b);
            end
            send_pixel(t_grad'(directed[r].gx), t_grad'(directed[r].gy),
                       directed[r].last, directed[r].typed, want);
        end

        // Random cells in three idling phases; two long cells of near-max
        // horizontal votes push bins 0 and 8 through the 26-bit wrap.
        items     = 0;
        phase     = 0;
        n_ovf     = 0;
        ovf_at[0] = 200;
        ovf_at[1] = 1100;
        while (items < RANDOM_PIXELS) begin
            new_phase = items * 3 / RANDOM_PIXELS;
            if (new_phase != phase) begin
                drain_results();
                phase = new_phase;
                if (phase == 1) begin
                    tx_idle_pct = 81;
                    rx_idle_pct = 35;
                end else begin
                    tx_idle_pct  = 0;
                    rx_idle_pct  = 0;
                    hold_request = 1'b1;   // sender keeps pushing into the hold
                end
            end
            if (n_ovf < 2 && items >= ovf_at[n_ovf]) begin
                for (int p = 0; p < OVERFLOW_LEN; p++) begin
                    m = $urandom_range(122, 128);
                    send_pixel(t_grad'((m == 128 || $urandom_range(0, 1)) ? -m : m),
                               '0, (p == OVERFLOW_LEN - 1), 1'b0, '0);
                end
                items += OVERFLOW_LEN;
                n_ovf++;
            end else begin
                len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12)
                                                   : $urandom_range(13, 60);
                for (int p = 0; p < len; p++) begin
                    send_pixel(random_grad(), random_grad(), (p == len - 1), 1'b0, '0);
                end
                items += len;
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (expected_hists.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_hists.size() != 0) begin
            $error("%0d cell histograms never came out", expected_hists.size());
            n_fail++;
        end
        repeat (8) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/coh_pkg.sv
hdl/hog_cell_orientation_histogram.sv
tb/sv/testbench.sv
